// ===== design/rpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants of the rigid point transform: default widths,
// configuration register indexes and the matrix settle count.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned QUAT_WIDTH_DEF  = 16;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_QUAT_W  = 3'd0,
    IDX_QUAT_X  = 3'd1,
    IDX_QUAT_Y  = 3'd2,
    IDX_QUAT_Z  = 3'd3,
    IDX_SHIFT_X = 3'd4,
    IDX_SHIFT_Y = 3'd5,
    IDX_SHIFT_Z = 3'd6
  } cfg_idx_e;

  // cycles the matrix setup path needs after a register write
  localparam int unsigned SETTLE_CYC = 2;
  localparam int unsigned SETTLE_W   = $clog2(SETTLE_CYC + 1);

endpackage

// ===== design/rpt_point_if.sv =====
// ----------------------------------------------------------------------------
// rpt_point_if
// Input stream channel: one word is one 3D point in signed fixed point.
// ----------------------------------------------------------------------------
interface rpt_point_if
  import rpt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);

endinterface

// ===== design/rpt_moved_if.sv =====
// ----------------------------------------------------------------------------
// rpt_moved_if
// Output stream channel: one word is one transformed point and its clip flag.
// ----------------------------------------------------------------------------
interface rpt_moved_if
  import rpt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] moved_x;
  logic signed [COORD_WIDTH-1:0] moved_y;
  logic signed [COORD_WIDTH-1:0] moved_z;
  logic                          clipped;

  modport source (output valid, output moved_x, output moved_y, output moved_z,
                  output clipped, input ready);
  modport sink   (input valid, input moved_x, input moved_y, input moved_z,
                  input clipped, output ready);

endinterface

// ===== design/rigid_point_transform.sv =====
// ----------------------------------------------------------------------------
// rigid_point_transform
// Rotates each point by a quaternion pose and adds a translation, with
// saturation of every output coordinate.
// ----------------------------------------------------------------------------
// The block takes one point per cycle unless a stalled output or a register
// write or matrix settle holds the input off. The pipeline has four stages:
// input register, nine matrix-by-coordinate products, rounded row sums, and
// translation add with saturation into the output register. A stalled output
// holds only the stages that are full. The rotation matrix is rebuilt from
// the quaternion registers by a two-stage setup path (squares and cross
// products, then rounded matrix entries). Input ready stays low in the cycle
// of a register write, and after it and after reset until the settle counter
// has run down to zero.
module rigid_point_transform
  import rpt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned QUAT_WIDTH  = QUAT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [((COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH)-1:0] cfg_data_i,
  rpt_point_if.sink              pnt_i,
  rpt_moved_if.source            mvd_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned QW = QUAT_WIDTH;
  localparam int unsigned F  = QW - 1;
  localparam int unsigned QP = 2 * QW;
  localparam int unsigned EW = 2 * QW + 2;
  localparam int unsigned MW = EW - F;
  localparam int unsigned PW = MW + CW;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned RW = AW - F;
  localparam int unsigned TW = RW + 1;

  localparam logic signed [EW-1:0] ONE_E  = {{(EW-1){1'b0}}, 1'b1} << (2 * F);
  localparam logic signed [EW-1:0] HALF_E = {{(EW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [AW-1:0] HALF_A = {{(AW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [TW-1:0] MAX_T  = TW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [TW-1:0] MIN_T  = -MAX_T - TW'(1);
  localparam logic signed [CW-1:0] MAX_C  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_C  = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [MW-1:0] round_entry(input logic signed [EW-1:0] e);
    logic signed [EW-1:0] s;
    s = e + HALF_E;
    return s[EW-1:F];
  endfunction

  // configuration registers: quaternion w, x, y, z and translation x, y, z
  logic signed [QW-1:0]       quat_q [4];
  logic signed [CW-1:0]       shift_q [3];
  logic        [SETTLE_W-1:0] settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[0] <= {1'b0, {F{1'b1}}};
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
      settle_q <= SETTLE_W'(SETTLE_CYC);
    end else begin
      if (cfg_we_i) begin
        settle_q <= SETTLE_W'(SETTLE_CYC);
        unique case (cfg_idx_e'(cfg_idx_i))
          IDX_QUAT_W:  quat_q[0]  <= cfg_data_i[QW-1:0];
          IDX_QUAT_X:  quat_q[1]  <= cfg_data_i[QW-1:0];
          IDX_QUAT_Y:  quat_q[2]  <= cfg_data_i[QW-1:0];
          IDX_QUAT_Z:  quat_q[3]  <= cfg_data_i[QW-1:0];
          IDX_SHIFT_X: shift_q[0] <= cfg_data_i[CW-1:0];
          IDX_SHIFT_Y: shift_q[1] <= cfg_data_i[CW-1:0];
          IDX_SHIFT_Z: shift_q[2] <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - SETTLE_W'(1);
      end
    end
  end

  // matrix setup, stage one: quaternion products
  logic signed [QP-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q, pwx_q, pwy_q, pwz_q;

  always_ff @(posedge clk_i) begin
    pxx_q <= QP'(quat_q[1]) * QP'(quat_q[1]);
    pyy_q <= QP'(quat_q[2]) * QP'(quat_q[2]);
    pzz_q <= QP'(quat_q[3]) * QP'(quat_q[3]);
    pxy_q <= QP'(quat_q[1]) * QP'(quat_q[2]);
    pxz_q <= QP'(quat_q[1]) * QP'(quat_q[3]);
    pyz_q <= QP'(quat_q[2]) * QP'(quat_q[3]);
    pwx_q <= QP'(quat_q[0]) * QP'(quat_q[1]);
    pwy_q <= QP'(quat_q[0]) * QP'(quat_q[2]);
    pwz_q <= QP'(quat_q[0]) * QP'(quat_q[3]);
  end

  // matrix setup, stage two: rounded entries, row major
  logic signed [MW-1:0] mat_d [9];
  logic signed [MW-1:0] mat_q [9];

  always_comb begin
    mat_d[0] = round_entry(ONE_E - ((EW'(pyy_q) + EW'(pzz_q)) <<< 1));
    mat_d[1] = round_entry((EW'(pxy_q) - EW'(pwz_q)) <<< 1);
    mat_d[2] = round_entry((EW'(pxz_q) + EW'(pwy_q)) <<< 1);
    mat_d[3] = round_entry((EW'(pxy_q) + EW'(pwz_q)) <<< 1);
    mat_d[4] = round_entry(ONE_E - ((EW'(pxx_q) + EW'(pzz_q)) <<< 1));
    mat_d[5] = round_entry((EW'(pyz_q) - EW'(pwx_q)) <<< 1);
    mat_d[6] = round_entry((EW'(pxz_q) - EW'(pwy_q)) <<< 1);
    mat_d[7] = round_entry((EW'(pyz_q) + EW'(pwx_q)) <<< 1);
    mat_d[8] = round_entry(ONE_E - ((EW'(pxx_q) + EW'(pyy_q)) <<< 1));
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      mat_q[k] <= mat_d[k];
    end
  end

  // data pipeline
  logic [3:0] vld_q;
  logic [3:0] rdy;
  logic       in_acc;

  assign rdy[3] = !vld_q[3] || mvd_o.ready;
  assign rdy[2] = !vld_q[2] || rdy[3];
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];

  assign pnt_i.ready = rdy[0] && !cfg_we_i && (settle_q == '0);
  assign in_acc      = pnt_i.valid && pnt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_acc;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
    end
  end

  logic signed [CW-1:0] pnt_q [3];
  logic signed [PW-1:0] prod_q [9];
  logic signed [RW-1:0] row_d [3];
  logic signed [RW-1:0] row_q [3];
  logic signed [CW-1:0] mov_d [3];
  logic signed [CW-1:0] mov_q [3];
  logic                 clip_d;
  logic                 clip_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pnt_q[0] <= pnt_i.point_x;
      pnt_q[1] <= pnt_i.point_y;
      pnt_q[2] <= pnt_i.point_z;
    end
    if (rdy[1]) begin
      for (int k = 0; k < 9; k++) begin
        prod_q[k] <= PW'(mat_q[k]) * PW'(pnt_q[k % 3]);
      end
    end
    if (rdy[2]) begin
      for (int r = 0; r < 3; r++) begin
        row_q[r] <= row_d[r];
      end
    end
    if (rdy[3]) begin
      for (int r = 0; r < 3; r++) begin
        mov_q[r] <= mov_d[r];
      end
      clip_q <= clip_d;
    end
  end

  always_comb begin
    logic signed [AW-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = AW'(prod_q[3*r]) + AW'(prod_q[3*r+1]) + AW'(prod_q[3*r+2]) + HALF_A;
      row_d[r] = acc[AW-1:F];
    end
  end

  always_comb begin
    logic signed [TW-1:0] tot;
    clip_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      tot = TW'(row_q[r]) + TW'(shift_q[r]);
      if (tot > MAX_T) begin
        mov_d[r] = MAX_C;
        clip_d   = 1'b1;
      end else if (tot < MIN_T) begin
        mov_d[r] = MIN_C;
        clip_d   = 1'b1;
      end else begin
        mov_d[r] = tot[CW-1:0];
      end
    end
  end

  assign mvd_o.valid   = vld_q[3];
  assign mvd_o.moved_x = mov_q[0];
  assign mvd_o.moved_y = mov_q[1];
  assign mvd_o.moved_z = mov_q[2];
  assign mvd_o.clipped = clip_q;

  // hold off input while the matrix settles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_acc)
    else $error("input word accepted one cycle after a register write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> ##2 !in_acc)
    else $error("input word accepted two cycles after a register write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[3]) |-> $past(vld_q[2]))
    else $error("output word appeared without a word in the previous stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mvd_o.valid && mvd_o.clipped) |->
      (mvd_o.moved_x == MAX_C || mvd_o.moved_x == MIN_C ||
       mvd_o.moved_y == MAX_C || mvd_o.moved_y == MIN_C ||
       mvd_o.moved_z == MAX_C || mvd_o.moved_z == MIN_C))
    else $error("clip flag set but no coordinate at a limit");

endmodule
